### hdl/htb_pkg.sv
`default_nettype none

package htb_pkg;

    // Default limit on decoded bytes per line
    localparam int MAX_BYTES_DEF = 128;

    // Depth of the queue between the classifier and the executor
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;

    typedef enum logic [2:0] {
        CLS_WS,
        CLS_SEP,
        CLS_HEX,
        CLS_X,
        CLS_NUL,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       done_res;
        t_status    status;
        logic [7:0] byte_count;
    } t_out;

    // One classified character as it travels through the queue
    typedef struct packed {
        t_cls       cls;
        logic       zero_char;
        logic [3:0] nibble;
        logic       last;
    } t_item;

endpackage

`default_nettype wire

### hdl/htb_classify.sv
`default_nettype none

module htb_classify import htb_pkg::*; (
    input  var t_in   i_char,
    output t_item     o_item
);

    logic [7:0] c;
    logic [7:0] val;

    assign c = i_char.char_code;

    always_comb begin
        o_item.cls       = CLS_OTHER;
        o_item.zero_char = (c == CH_ZERO);
        o_item.last      = i_char.end_of_line;
        val              = 8'd0;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            o_item.cls = CLS_WS;
        end else if (c == CH_COMMA || c == CH_COLON) begin
            o_item.cls = CLS_SEP;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            o_item.cls = CLS_HEX;
            val        = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LF) begin
            o_item.cls = CLS_HEX;
            val        = c - CH_LA + HEX_ALPHA_OFFSET;
        end else if (c >= CH_UA && c <= CH_UF) begin
            o_item.cls = CLS_HEX;
            val        = c - CH_UA + HEX_ALPHA_OFFSET;
        end else if (c == CH_LX || c == CH_UX) begin
            o_item.cls = CLS_X;
        end else if (c == CH_NUL) begin
            o_item.cls = CLS_NUL;
        end
        o_item.nibble = val[3:0];
    end

endmodule

`default_nettype wire

### hdl/htb_queue.sv
`default_nettype none

module htb_queue import htb_pkg::*; (
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    input  var logic  i_push,
    input  var t_item i_item,
    output logic      o_full,
    input  var logic  i_pop,
    output logic      o_nonempty,
    output t_item     o_item
);

    localparam int QA = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [QA-1:0]   r_wr_ptr;
    logic [QA-1:0]   r_rd_ptr;
    logic [QC-1:0]   r_count;
    logic [QA-1:0]   n_wr_ptr;
    logic [QA-1:0]   n_rd_ptr;
    logic [QC-1:0]   n_count;

    assign o_full     = (r_count == QC'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QA'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QA'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QA'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QA'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QC'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QC'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### hdl/htb_exec.sv
`default_nettype none

module htb_exec import htb_pkg::*; #(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    input  var logic  i_q_nonempty,
    input  var t_item i_item,
    output logic      o_pop,
    output logic      o_out_valid,
    input  var logic  i_out_ready,
    output t_out      o_out_data
);

    localparam int CW = $clog2(MAX_BYTES + 1);

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DECODE = 3'b010,
        PH_HALT   = 3'b100
    } t_phase;

    t_phase          r_phase;
    logic            r_pending;
    logic [3:0]      r_high;
    logic            r_expect;
    logic [CW-1:0]   r_count;
    logic            r_error;
    logic            r_out_valid;
    t_out            r_out;

    t_phase          n_phase;
    logic            n_pending;
    logic [3:0]      n_high;
    logic            n_expect;
    logic [CW-1:0]   n_count;
    logic            n_error;

    logic            do_decode;
    logic            got;
    logic [7:0]      data;
    logic [CW-1:0]   cnt_m1;
    logic [CW+7:0]   cnt_ext;
    t_status         status;
    t_out            result;

    assign o_pop       = i_q_nonempty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_high    = r_high;
        n_expect  = r_expect;
        n_count   = r_count;
        n_error   = r_error;
        do_decode = 1'b0;
        got       = 1'b0;
        data      = 8'd0;

        unique case (r_phase)
            PH_LEAD: begin
                if (r_pending) begin
                    // Held '0' resolves: prefix, or the high nibble of data
                    n_pending = 1'b0;
                    n_phase   = PH_DECODE;
                    if (i_item.cls != CLS_X) begin
                        n_high    = 4'd0;
                        n_expect  = 1'b0;
                        do_decode = 1'b1;
                    end
                end else if (i_item.cls == CLS_WS) begin
                    n_phase = PH_LEAD;
                end else if (i_item.zero_char) begin
                    n_pending = 1'b1;
                end else if (i_item.cls == CLS_NUL) begin
                    n_phase = PH_HALT;
                end else begin
                    n_phase   = PH_DECODE;
                    do_decode = 1'b1;
                end
            end
            PH_DECODE: do_decode = 1'b1;
            PH_HALT:   n_phase = PH_HALT;
            default:   n_phase = r_phase;
        endcase

        if (do_decode) begin
            if (n_count >= CW'(MAX_BYTES) || i_item.cls == CLS_NUL) begin
                n_phase = PH_HALT;
            end else if (i_item.cls == CLS_WS || i_item.cls == CLS_SEP) begin
                n_phase = n_phase;
            end else if (i_item.cls != CLS_HEX) begin
                n_error = 1'b1;
                n_phase = PH_HALT;
            end else if (n_expect) begin
                n_high   = i_item.nibble;
                n_expect = 1'b0;
            end else begin
                data     = {n_high, i_item.nibble};
                n_count  = n_count + CW'(1);
                n_expect = 1'b1;
                got      = 1'b1;
            end
        end

        // A '0' still pending at end of line counts as a lone high nibble
        if (i_item.last && n_pending) begin
            n_expect = 1'b0;
        end

        cnt_m1  = n_count - CW'(1);
        cnt_ext = {8'd0, n_count};
        if (n_error) begin
            status = ST_BAD_CHAR;
        end else if (n_count != '0 && (n_count & cnt_m1) == '0 && n_expect) begin
            status = ST_OK;
        end else begin
            status = ST_BAD_LEN;
        end

        result.byte_valid = got;
        result.data_byte  = data;
        result.done_res   = i_item.last;
        result.status     = i_item.last ? status : ST_OK;
        result.byte_count = cnt_ext[7:0];

        // Drop all line state after the last character
        if (i_item.last) begin
            n_phase   = PH_LEAD;
            n_pending = 1'b0;
            n_high    = 4'd0;
            n_expect  = 1'b1;
            n_count   = '0;
            n_error   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_pending   <= 1'b0;
            r_high      <= 4'd0;
            r_expect    <= 1'b1;
            r_count     <= '0;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_high    <= n_high;
                r_expect  <= n_expect;
                r_count   <= n_count;
                r_error   <= n_error;
            end
            if (o_pop && (got || i_item.last)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (got || i_item.last)) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

### hdl/hex_text_to_bytes_parser.sv
// Path: a character is queued, then decoded from the queue into the output register.
// Throughput: one character per cycle, sustained while the output side keeps taking
// transactions; set by the per-character state update in the executor.
// Reset: synchronous, active low; empties the queue and output register and puts
// the line state into the leading-whitespace phase.
`default_nettype none

module hex_text_to_bytes_parser import htb_pkg::*; #(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_in_valid,
    output logic     o_in_ready,
    input  var t_in  i_in_data,
    output logic     o_out_valid,
    input  var logic i_out_ready,
    output t_out     o_out_data
);

    // Front end: classify each incoming character into a compact token
    // (whitespace, separator, hex digit with its nibble, x, NUL, other).
    t_item cls_item;
    t_item q_item;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    logic  q_push;

    htb_classify u_classify (
        .i_char (i_in_data),
        .o_item (cls_item)
    );

    // Accept a transaction whenever the queue has room; the executor may
    // be stalled on its output register without holding off the input.
    assign o_in_ready = !q_full;
    assign q_push     = i_in_valid && o_in_ready;

    htb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (cls_item),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_item     (q_item)
    );

    // Back end: run the line decoder on each token, emit a result when a
    // byte completes or the line ends, and hold it until it is taken.
    htb_exec #(
        .MAX_BYTES (MAX_BYTES)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
